// ===== rtl/core/cpq_pkg.sv =====
// ----------------------------------------------------------------------------
// cpq_pkg
// Types and codes shared by the coalescing priority packet queue.
// ----------------------------------------------------------------------------
package cpq_pkg;

	// Command codes
	localparam logic [1:0] MODE_PUSH_NORMAL   = 2'd0;
	localparam logic [1:0] MODE_PUSH_PRIORITY = 2'd1;
	localparam logic [1:0] MODE_POP           = 2'd2;
	localparam logic [1:0] MODE_FAIL          = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_ENQUEUED  = 3'd0;
	localparam logic [2:0] ST_COALESCED = 3'd1;
	localparam logic [2:0] ST_DROPPED   = 3'd2;
	localparam logic [2:0] ST_POPPED    = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_FAILURE   = 3'd5;

	// Stored entries of this type may be overwritten by a newer packet
	localparam logic [7:0] COALESCE_TYPE = 8'd1;

	localparam int ENTRY_W = 128;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  packet_type;
		logic [7:0]  packet_hid;
		logic [63:0] payload_low;
		logic [47:0] payload_high;
		logic [5:0]  lost_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        from_priority;
		logic [7:0]  out_type;
		logic [7:0]  out_hid;
		logic [63:0] out_payload_low;
		logic [47:0] out_payload_high;
		logic [31:0] dropped_total;
		logic [31:0] failure_total;
	} out_item_t;

	// One stored packet, exactly ENTRY_W bits wide
	typedef struct packed {
		logic [7:0]  ptype;
		logic [7:0]  hid;
		logic [63:0] lo;
		logic [47:0] hi;
	} entry_t;

	// Tag table update from the controller
	typedef struct packed {
		logic       wr_en;
		logic       append;
		logic       pop;
		logic       coal;
		logic [7:0] hid;
	} tag_upd_t;

endpackage

// ===== rtl/core/cpq_ram.sv =====
// ----------------------------------------------------------------------------
// cpq_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module cpq_ram import cpq_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/cpq_match.sv =====
// ----------------------------------------------------------------------------
// cpq_match
// Hid tag table of the normal queue with pending bits; finds the oldest
// pending coalescible entry that carries a given hid.
// ----------------------------------------------------------------------------
module cpq_match import cpq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     capture,
	input  logic [7:0]               key_hid,
	input  logic [$clog2(DEPTH)-1:0] tail,
	input  tag_upd_t                 upd,
	input  logic [$clog2(DEPTH)-1:0] upd_idx,
	output logic                     hit,
	output logic [$clog2(DEPTH)-1:0] hit_idx
);

	localparam int AW = $clog2(DEPTH);

	logic [DEPTH-1:0] pend_q;
	logic [DEPTH-1:0] coal_q;
	logic [7:0]       hid_q [DEPTH];
	logic [DEPTH-1:0] match_s1;
	logic [DEPTH-1:0] match_vec;

	logic          found_hi, found_lo;
	logic [AW-1:0] idx_hi, idx_lo;

	// Track which entries are pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			if (upd.wr_en && upd.append) pend_q[upd_idx] <= 1'b1;
			if (upd.pop) pend_q[tail] <= 1'b0;
		end
	end

	// Hold tags of written entries
	always_ff @(posedge clk) begin
		if (upd.wr_en) begin
			hid_q[upd_idx]  <= upd.hid;
			coal_q[upd_idx] <= upd.coal;
		end
	end

	// Compare all tags in parallel
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_vec[i] = pend_q[i] && coal_q[i] && (hid_q[i] == key_hid);
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			match_s1 <= match_vec;
		end
	end

	// Oldest hit: first match at or after tail, else first match below tail
	always_comb begin
		found_hi = 1'b0;
		found_lo = 1'b0;
		idx_hi   = '0;
		idx_lo   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				found_lo = 1'b1;
				idx_lo   = AW'(i);
				if (AW'(i) >= tail) begin
					found_hi = 1'b1;
					idx_hi   = AW'(i);
				end
			end
		end
	end

	assign hit     = found_lo;
	assign hit_idx = found_hi ? idx_hi : idx_lo;

endmodule

// ===== rtl/core/coalescing_priority_packet_queue_top.sv =====
// ----------------------------------------------------------------------------
// coalescing_priority_packet_queue_top
// Normal and priority packet queues with coalescing of normal pushes.
// ----------------------------------------------------------------------------
// Usage:
//   Drive packet and raise start; the item is taken at the edge where start
//   is high and busy is low. Modes: push normal, push priority, pop, record
//   send failure. busy is high for exactly one cycle after each item.
//   In the cycle right after the busy cycle, done pulses for one cycle with
//   result; the receiver must take it then, it cannot stall the block.
//   The result is registered at the end of the busy cycle, and no new item is
//   taken while busy is high. The accept cycle compares the hid against the
//   parallel tag table of the normal queue and reads both queue memories at
//   their tails; the next cycle picks the oldest match and does the one write,
//   if any.
//   Packet contents live in two synchronous memories (one write, one read
//   port each); hid tags and pending bits live in flip-flops.
//   Reset (arst_n low) empties both queues and clears both counters; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module coalescing_priority_packet_queue_top import cpq_pkg::*; #(
	parameter int NORMAL_DEPTH   = 32,
	parameter int PRIORITY_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  packet,
	output logic      done,
	output out_item_t result
);

	localparam int NW = $clog2(NORMAL_DEPTH);
	localparam int PW = $clog2(PRIORITY_DEPTH);

	typedef enum logic {IDLE, EXEC} state_t;

	state_t    state_q;
	in_item_t  pkt_s1;
	out_item_t result_q;
	logic      done_q;

	logic [NW-1:0] nrm_head_q, nrm_tail_q, nrm_head_d, nrm_tail_d, nrm_head_inc, nrm_tail_inc;
	logic [PW-1:0] pri_head_q, pri_tail_q, pri_head_d, pri_tail_d, pri_head_inc, pri_tail_inc;
	logic          nrm_full_q, nrm_full_d, pri_full_q, pri_full_d;
	logic [31:0]   dropped_q, dropped_d, failure_q, failure_d;

	logic          accept;
	logic          nrm_we, pri_we;
	logic [NW-1:0] nrm_waddr;
	entry_t        wentry, nrm_rd, pri_rd;
	logic          hit;
	logic [NW-1:0] hit_idx;
	tag_upd_t      upd;
	logic [NW-1:0] upd_idx;
	out_item_t     res_d;

	assign accept = start && (state_q == IDLE);
	assign busy   = (state_q == EXEC);
	assign done   = done_q;
	assign result = result_q;

	// Hold the item for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_s1 <= packet;
		end
	end

	assign wentry = '{ptype: pkt_s1.packet_type, hid: pkt_s1.packet_hid,
		lo: pkt_s1.payload_low, hi: pkt_s1.payload_high};

	cpq_ram #(.DEPTH(NORMAL_DEPTH), .WIDTH(ENTRY_W)) u_nrm_ram (
		.clk   (clk),
		.we    (nrm_we),
		.waddr (nrm_waddr),
		.wdata (wentry),
		.re    (accept),
		.raddr (nrm_tail_q),
		.rdata (nrm_rd)
	);

	cpq_ram #(.DEPTH(PRIORITY_DEPTH), .WIDTH(ENTRY_W)) u_pri_ram (
		.clk   (clk),
		.we    (pri_we),
		.waddr (pri_head_q),
		.wdata (wentry),
		.re    (accept),
		.raddr (pri_tail_q),
		.rdata (pri_rd)
	);

	cpq_match #(.DEPTH(NORMAL_DEPTH)) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (accept),
		.key_hid (packet.packet_hid),
		.tail    (nrm_tail_q),
		.upd     (upd),
		.upd_idx (upd_idx),
		.hit     (hit),
		.hit_idx (hit_idx)
	);

	// Advance pointers with wrap
	assign nrm_head_inc = (nrm_head_q == NW'(NORMAL_DEPTH - 1)) ? '0 : nrm_head_q + 1'b1;
	assign nrm_tail_inc = (nrm_tail_q == NW'(NORMAL_DEPTH - 1)) ? '0 : nrm_tail_q + 1'b1;
	assign pri_head_inc = (pri_head_q == PW'(PRIORITY_DEPTH - 1)) ? '0 : pri_head_q + 1'b1;
	assign pri_tail_inc = (pri_tail_q == PW'(PRIORITY_DEPTH - 1)) ? '0 : pri_tail_q + 1'b1;

	// Execute the held item
	always_comb begin
		nrm_we     = 1'b0;
		pri_we     = 1'b0;
		nrm_waddr  = nrm_head_q;
		upd        = '0;
		upd.coal   = (pkt_s1.packet_type == COALESCE_TYPE);
		upd.hid    = pkt_s1.packet_hid;
		upd_idx    = nrm_head_q;
		nrm_head_d = nrm_head_q;
		nrm_tail_d = nrm_tail_q;
		nrm_full_d = nrm_full_q;
		pri_head_d = pri_head_q;
		pri_tail_d = pri_tail_q;
		pri_full_d = pri_full_q;
		dropped_d  = dropped_q;
		failure_d  = failure_q;
		res_d      = '0;
		if (state_q == EXEC) begin
			case (pkt_s1.mode)
				MODE_PUSH_NORMAL: begin
					if (hit) begin
						nrm_we       = 1'b1;
						nrm_waddr    = hit_idx;
						upd.wr_en    = 1'b1;
						upd_idx      = hit_idx;
						res_d.status = ST_COALESCED;
					end else if (nrm_full_q) begin
						dropped_d    = dropped_q + 32'd1;
						res_d.status = ST_DROPPED;
					end else begin
						nrm_we       = 1'b1;
						upd.wr_en    = 1'b1;
						upd.append   = 1'b1;
						nrm_head_d   = nrm_head_inc;
						nrm_full_d   = (nrm_head_inc == nrm_tail_q);
						res_d.status = ST_ENQUEUED;
					end
				end
				MODE_PUSH_PRIORITY: begin
					if (pri_full_q) begin
						dropped_d    = dropped_q + 32'd1;
						res_d.status = ST_DROPPED;
					end else begin
						pri_we       = 1'b1;
						pri_head_d   = pri_head_inc;
						pri_full_d   = (pri_head_inc == pri_tail_q);
						res_d.status = ST_ENQUEUED;
					end
				end
				MODE_POP: begin
					if (pri_full_q || (pri_head_q != pri_tail_q)) begin
						pri_tail_d             = pri_tail_inc;
						pri_full_d             = 1'b0;
						res_d.status           = ST_POPPED;
						res_d.from_priority    = 1'b1;
						res_d.out_type         = pri_rd.ptype;
						res_d.out_hid          = pri_rd.hid;
						res_d.out_payload_low  = pri_rd.lo;
						res_d.out_payload_high = pri_rd.hi;
					end else if (nrm_full_q || (nrm_head_q != nrm_tail_q)) begin
						upd.pop                = 1'b1;
						nrm_tail_d             = nrm_tail_inc;
						nrm_full_d             = 1'b0;
						res_d.status           = ST_POPPED;
						res_d.out_type         = nrm_rd.ptype;
						res_d.out_hid          = nrm_rd.hid;
						res_d.out_payload_low  = nrm_rd.lo;
						res_d.out_payload_high = nrm_rd.hi;
					end else begin
						res_d.status = ST_EMPTY;
					end
				end
				MODE_FAIL: begin
					failure_d    = failure_q + 32'd1;
					dropped_d    = dropped_q + 32'(pkt_s1.lost_count);
					res_d.status = ST_FAILURE;
				end
				default: begin
					res_d.status = ST_EMPTY;
				end
			endcase
		end
		res_d.dropped_total = dropped_d;
		res_d.failure_total = failure_d;
	end

	// State, queue pointers, counters and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			nrm_head_q <= '0;
			nrm_tail_q <= '0;
			nrm_full_q <= 1'b0;
			pri_head_q <= '0;
			pri_tail_q <= '0;
			pri_full_q <= 1'b0;
			dropped_q  <= '0;
			failure_q  <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) state_q <= EXEC;
				end
				EXEC: begin
					nrm_head_q <= nrm_head_d;
					nrm_tail_q <= nrm_tail_d;
					nrm_full_q <= nrm_full_d;
					pri_head_q <= pri_head_d;
					pri_tail_q <= pri_tail_d;
					pri_full_q <= pri_full_d;
					dropped_q  <= dropped_d;
					failure_q  <= failure_d;
					result_q   <= res_d;
					done_q     <= 1'b1;
					state_q    <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/cpq_checker.sv =====
// ----------------------------------------------------------------------------
// cpq_checker
// Port-level checks of the coalescing priority packet queue.
// ----------------------------------------------------------------------------
module cpq_checker import cpq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t result
);

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// Each item keeps busy high one cycle, then reports
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("busy cycle not followed by a result");

	// A result only follows a busy cycle
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item");

	// Only a pop carries a packet
	a_no_packet: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_POPPED) |->
		!result.from_priority && (result.out_type == 8'd0) && (result.out_hid == 8'd0))
		else $error("packet fields set on a non-pop result");

endmodule

bind coalescing_priority_packet_queue_top cpq_checker u_cpq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
